// ===== rtl/pomo_pkg.sv =====
// Package for the pomodoro timer: register indexes, reset values,
// status LED colors and the result record.
// No dependencies.
package pomo_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WORK_SECONDS   = 2'd0,
		CFG_REST_SECONDS   = 2'd1,
		CFG_TICK_PERIOD_MS = 2'd2,
		CFG_DEBOUNCE_MS    = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_BITS = 16;
	localparam int unsigned SEC_BITS      = 12;
	localparam int unsigned PAGE_BITS     = 2;  // four pages, wraps naturally
	localparam int unsigned NUM_KEYS      = 3;

	localparam logic [SEC_BITS-1:0]  MAX_SECONDS        = 12'd3600;
	localparam logic [SEC_BITS-1:0]  WORK_SECONDS_RST   = 12'd1500;
	localparam logic [SEC_BITS-1:0]  REST_SECONDS_RST   = 12'd300;
	localparam logic [15:0]          TICK_PERIOD_RST    = 16'd1000;
	localparam logic [15:0]          DEBOUNCE_RST       = 16'd250;
	localparam logic [PAGE_BITS-1:0] POMO_PAGE          = 2'd2;

	// divide by 60 through a reciprocal: exact for values up to 4095
	localparam logic [14:0] DIV60_RECIP = 15'd17477;
	localparam int unsigned DIV60_SHIFT = 20;

	// key slots
	localparam int unsigned KEY_PAGE  = 0;
	localparam int unsigned KEY_START = 1;
	localparam int unsigned KEY_RESET = 2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page;
		logic                 running;
		logic                 work_phase;
		logic [SEC_BITS-1:0]  seconds_left;
		logic [5:0]           display_minutes;
		logic [5:0]           display_seconds;
		rgb_t                 led;
	} result_t;

	// status LED color by page and phase
	function automatic rgb_t led_color(input logic [PAGE_BITS-1:0] page, input logic work);
		rgb_t c;
		case (page)
			2'd0:      c = rgb_t'{8'd100, 8'd0, 8'd255};
			2'd1:      c = rgb_t'{8'd255, 8'd0, 8'd0};
			POMO_PAGE: c = work ? rgb_t'{8'd0, 8'd255, 8'd0} : rgb_t'{8'd0, 8'd0, 8'd255};
			default:   c = rgb_t'{8'd200, 8'd255, 8'd255};
		endcase
		return c;
	endfunction

	// loaded durations saturate at one hour
	function automatic logic [SEC_BITS-1:0] clamp_duration(input logic [SEC_BITS-1:0] d);
		return (d > MAX_SECONDS) ? MAX_SECONDS : d;
	endfunction

endpackage

// ===== rtl/pomo_if.sv =====
// Channel interfaces for the pomodoro timer: key/timestamp samples in,
// status records out. Valid/ready handshake. No dependencies.
interface pomo_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        key_page;
	logic        key_start_pause;
	logic        key_reset;

	modport source (output valid, now_ms, key_page, key_start_pause, key_reset, input ready);
	modport sink   (input valid, now_ms, key_page, key_start_pause, key_reset, output ready);
endinterface

interface pomo_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  page;
	logic        running;
	logic        work_phase;
	logic [11:0] seconds_left;
	logic [5:0]  display_minutes;
	logic [5:0]  display_seconds;
	logic [7:0]  led_red;
	logic [7:0]  led_green;
	logic [7:0]  led_blue;

	modport source (output valid, page, running, work_phase, seconds_left, display_minutes,
		display_seconds, led_red, led_green, led_blue, input ready);
	modport sink   (input valid, page, running, work_phase, seconds_left, display_minutes,
		display_seconds, led_red, led_green, led_blue, output ready);
endinterface

// ===== rtl/pomo_key.sv =====
// Edge detect and debounce for one key: fires on a rising level when more
// than the debounce time has passed since its last firing. Uses no package.
module pomo_key #(
	parameter int unsigned TS_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,      // sample is consumed this cycle
	input  logic               level,
	input  logic [TS_BITS-1:0] now,
	input  logic [TS_BITS-1:0] debounce,
	output logic               fire
);

	logic               prev_q;
	logic [TS_BITS-1:0] last_fire_q;
	logic [TS_BITS-1:0] elapsed;

	// wrapping time since last firing
	assign elapsed = now - last_fire_q;
	assign fire    = level && !prev_q && (elapsed > debounce);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 1'b0;
			last_fire_q <= '0;
		end else if (step) begin
			prev_q <= level;
			if (fire) begin
				last_fire_q <= now;
			end
		end
	end

endmodule

// ===== rtl/pomodoro_timer_with_debounced_keys.sv =====
// Pomodoro timer with debounced keys: top level.
// A sample is held in the input register, then loaded into the result register
// when that register is free or drained, and its status is offered from there.
// Throughput: one sample per cycle while the output is ready; a stalled output
// holds the input once both registers are full. Reset: asynchronous, page 0,
// stopped, work phase with 1500 s left, all key and tick times at zero,
// registers at 1500 / 300 / 1000 / 250. Uses pomo_pkg, pomo_if, pomo_key.
module pomodoro_timer_with_debounced_keys #(
	parameter int unsigned TIMESTAMP_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [pomo_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	pomo_in_if.sink                              in_ch,
	pomo_out_if.source                           out_ch
);

	localparam int unsigned SB = pomo_pkg::SEC_BITS;
	localparam int unsigned PB = pomo_pkg::PAGE_BITS;

	// configuration registers
	logic [SB-1:0] work_seconds_q;
	logic [SB-1:0] rest_seconds_q;
	logic [15:0]   tick_period_q;
	logic [15:0]   debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_seconds_q <= pomo_pkg::WORK_SECONDS_RST;
			rest_seconds_q <= pomo_pkg::REST_SECONDS_RST;
			tick_period_q  <= pomo_pkg::TICK_PERIOD_RST;
			debounce_q     <= pomo_pkg::DEBOUNCE_RST;
		end else if (cfg_we) begin
			case (pomo_pkg::cfg_idx_t'(cfg_index))
				pomo_pkg::CFG_WORK_SECONDS:   work_seconds_q <= cfg_data[SB-1:0];
				pomo_pkg::CFG_REST_SECONDS:   rest_seconds_q <= cfg_data[SB-1:0];
				pomo_pkg::CFG_TICK_PERIOD_MS: tick_period_q  <= cfg_data[15:0];
				pomo_pkg::CFG_DEBOUNCE_MS:    debounce_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or drained
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;
	logic    in_xfer;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_xfer     = in_ch.valid && in_ch.ready;

	// input register
	logic [31:0]                    now_s1;
	logic [pomo_pkg::NUM_KEYS-1:0]  keys_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_s1  <= in_ch.now_ms;
			keys_s1 <= {in_ch.key_reset, in_ch.key_start_pause, in_ch.key_page};
		end
	end

	// timestamp and limits at the internal time width
	logic [63:0]               now_wide;
	logic [TIMESTAMP_BITS-1:0] now_ts;
	logic [TIMESTAMP_BITS-1:0] period_ts;
	logic [TIMESTAMP_BITS-1:0] debounce_ts;

	assign now_wide    = 64'(now_s1);
	assign now_ts      = now_wide[TIMESTAMP_BITS-1:0];
	assign period_ts   = TIMESTAMP_BITS'(tick_period_q);
	assign debounce_ts = TIMESTAMP_BITS'(debounce_q);

	// timer state
	logic [PB-1:0]             page_q;
	logic                      run_q;
	logic                      work_q;
	logic [SB-1:0]             remaining_q;
	logic [TIMESTAMP_BITS-1:0] last_tick_q;

	// key units
	logic [pomo_pkg::NUM_KEYS-1:0] fire;

	for (genvar k = 0; k < pomo_pkg::NUM_KEYS; k++) begin : g_key
		pomo_key #(.TS_BITS(TIMESTAMP_BITS)) u_key (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (advance),
			.level    (keys_s1[k]),
			.now      (now_ts),
			.debounce (debounce_ts),
			.fire     (fire[k])
		);
	end

	// countdown tick, then key actions in page, start/pause, reset order
	logic [TIMESTAMP_BITS-1:0] tick_elapsed;
	logic                      tick;
	logic                      work_t;
	logic [SB-1:0]             rem_t;
	logic [TIMESTAMP_BITS-1:0] last_t;
	pomo_pkg::rgb_t            led;
	logic [PB-1:0]             page_n;
	logic                      run_n;
	logic                      work_n;
	logic [SB-1:0]             rem_n;
	logic [TIMESTAMP_BITS-1:0] last_n;

	assign tick_elapsed = now_ts - last_tick_q;
	assign tick         = run_q && (tick_elapsed > period_ts);

	always_comb begin
		work_t = work_q;
		rem_t  = remaining_q;
		last_t = last_tick_q;
		if (tick) begin
			last_t = now_ts;
			if (remaining_q != '0) begin
				rem_t = remaining_q - 1'b1;
			end else begin
				work_t = !work_q;
				rem_t  = pomo_pkg::clamp_duration(work_q ? rest_seconds_q : work_seconds_q);
			end
		end

		led = pomo_pkg::led_color(page_q, work_t);

		page_n = fire[pomo_pkg::KEY_PAGE] ? page_q + 1'b1 : page_q;
		run_n  = run_q;
		work_n = work_t;
		rem_n  = rem_t;
		last_n = last_t;
		if (fire[pomo_pkg::KEY_START] && page_n == pomo_pkg::POMO_PAGE) begin
			run_n  = !run_q;
			last_n = now_ts;
		end
		if (fire[pomo_pkg::KEY_RESET] && page_n == pomo_pkg::POMO_PAGE) begin
			run_n  = 1'b0;
			work_n = 1'b1;
			rem_n  = pomo_pkg::clamp_duration(work_seconds_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q      <= '0;
			run_q       <= 1'b0;
			work_q      <= 1'b1;
			remaining_q <= pomo_pkg::WORK_SECONDS_RST;
			last_tick_q <= '0;
		end else if (advance) begin
			page_q      <= page_n;
			run_q       <= run_n;
			work_q      <= work_n;
			remaining_q <= rem_n;
			last_tick_q <= last_n;
		end
	end

	// minutes and seconds split via reciprocal multiply
	logic [26:0]   div_prod;
	logic [5:0]    minutes;
	logic [SB-1:0] min_times60;
	logic [SB-1:0] sec_rem;

	assign div_prod    = 27'(rem_n) * 27'(pomo_pkg::DIV60_RECIP);
	assign minutes     = div_prod[pomo_pkg::DIV60_SHIFT +: 6];
	assign min_times60 = SB'(minutes) * SB'(60);
	assign sec_rem     = rem_n - min_times60;

	// result register
	pomo_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.page            <= page_n;
			res_q.running         <= run_n;
			res_q.work_phase      <= work_n;
			res_q.seconds_left    <= rem_n;
			res_q.display_minutes <= minutes;
			res_q.display_seconds <= sec_rem[5:0];
			res_q.led             <= led;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.page            = res_q.page;
	assign out_ch.running         = res_q.running;
	assign out_ch.work_phase      = res_q.work_phase;
	assign out_ch.seconds_left    = res_q.seconds_left;
	assign out_ch.display_minutes = res_q.display_minutes;
	assign out_ch.display_seconds = res_q.display_seconds;
	assign out_ch.led_red         = res_q.led.red;
	assign out_ch.led_green       = res_q.led.green;
	assign out_ch.led_blue        = res_q.led.blue;

	// remaining time never leaves the one-hour range
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= pomo_pkg::MAX_SECONDS)
		else $error("remaining time out of range");

	// display split is consistent with the seconds count
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.display_seconds < 6'd60) &&
		(SB'(res_q.display_minutes) * SB'(60) + SB'(res_q.display_seconds)
			== res_q.seconds_left))
		else $error("minutes/seconds split mismatch");

	// an empty result register never blocks the input side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// timer state only moves when a sample is consumed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(page_q) && $stable(run_q) && $stable(work_q) &&
		$stable(remaining_q))
		else $error("timer state changed without a sample");

endmodule
